@@ src/aso_pkg.sv @@
// Shared types and constants for the accelerometer oversampling averager.
`timescale 1ns / 1ps

package aso_pkg;

    // Stream framing: XH XL YH YL ZH ZL
    localparam int          NUM_AXES   = 3;
    localparam int          HOLD_DEPTH = 5;
    localparam logic [2:0]  LAST_POS   = 3'd5;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    // Word handed from the accumulator to the divide stage
    typedef struct packed {
        t_sample [NUM_AXES-1:0] sample;
        t_sum    [NUM_AXES-1:0] sum;
        logic                   done;
    } t_acc_word;

endpackage

@@ src/aso_accum.sv @@
// Byte assembly and per-axis running sums of the oversampling averager.
`timescale 1ns / 1ps

module aso_accum #(
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_byte,
    input  logic                i_adv,
    output logic                o_close,
    output aso_pkg::t_acc_word  o_word
);

    localparam logic [aso_pkg::COUNT_W-1:0] TARGET = aso_pkg::COUNT_W'(SAMPLES_PER_AVERAGE);

    logic [2:0]                   r_pos;
    logic [7:0]                   r_hold [aso_pkg::HOLD_DEPTH];
    aso_pkg::t_sum                r_sum  [aso_pkg::NUM_AXES];
    logic [aso_pkg::COUNT_W-1:0]  r_count;

    logic [aso_pkg::COUNT_W-1:0]  count_inc;
    aso_pkg::t_sample             samp   [aso_pkg::NUM_AXES];
    aso_pkg::t_sum                sum_nx [aso_pkg::NUM_AXES];

    // Positions past the last code also close the group
    assign o_close = (r_pos >= aso_pkg::LAST_POS);

    // Join high and low bytes per axis
    assign samp[0] = {r_hold[0], r_hold[1]};
    assign samp[1] = {r_hold[2], r_hold[3]};
    assign samp[2] = {r_hold[4], i_byte};

    assign count_inc = r_count + 1'b1;

    always_comb begin
        for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
            sum_nx[i] = r_sum[i] + {{(aso_pkg::SUM_W - aso_pkg::SAMPLE_W){samp[i][15]}}, samp[i]};
            o_word.sample[i] = samp[i];
            o_word.sum[i]    = sum_nx[i];
        end
        o_word.done = (count_inc >= TARGET);
    end

    // Held bytes: no reset, always written before use
    always_ff @(posedge i_clk) begin
        if (i_adv && !o_close) begin
            r_hold[r_pos] <= i_byte;
        end
    end

    // Position, sums and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_adv) begin
            if (!o_close) begin
                r_pos <= r_pos + 1'b1;
            end else begin
                r_pos <= '0;
                if (o_word.done) begin
                    r_count <= '0;
                    for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
                        r_sum[i] <= '0;
                    end
                end else begin
                    r_count <= count_inc;
                    for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
                        r_sum[i] <= sum_nx[i];
                    end
                end
            end
        end
    end

endmodule

@@ src/aso_divide.sv @@
// Constant divide of the three axis sums, truncating toward zero.
`timescale 1ns / 1ps

module aso_divide #(
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  aso_pkg::t_sum    [aso_pkg::NUM_AXES-1:0] i_sum,
    output aso_pkg::t_sample [aso_pkg::NUM_AXES-1:0] o_quot
);

    // Reciprocal ceil(2^SHIFT / N); exact for magnitudes below 2^24
    localparam int              SHIFT   = aso_pkg::SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int              RECIP_W = aso_pkg::SUM_W + 1;
    localparam int              PROD_W  = aso_pkg::SUM_W + RECIP_W;
    localparam int              QUOT_W  = aso_pkg::SAMPLE_W + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

    logic [aso_pkg::SUM_W-1:0] mag  [aso_pkg::NUM_AXES];
    logic [PROD_W-1:0]         prod [aso_pkg::NUM_AXES];
    logic [QUOT_W-1:0]         q    [aso_pkg::NUM_AXES];
    logic [QUOT_W-1:0]         qneg [aso_pkg::NUM_AXES];

    // One multiplier per axis on the magnitude, sign restored after
    always_comb begin
        for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
            mag[i]    = i_sum[i][aso_pkg::SUM_W-1] ? (~i_sum[i] + 1'b1) : i_sum[i];
            prod[i]   = PROD_W'(mag[i]) * PROD_W'(RECIP);
            q[i]      = prod[i][SHIFT +: QUOT_W];
            qneg[i]   = ~q[i] + 1'b1;
            o_quot[i] = i_sum[i][aso_pkg::SUM_W-1] ? qneg[i][aso_pkg::SAMPLE_W-1:0]
                                                  : q[i][aso_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

@@ src/accel_sample_oversampler_core.sv @@
// Top level of the accelerometer oversampling averager.
`timescale 1ns / 1ps

// Takes one sensor byte per cycle, unless stalled, in the order XH XL YH YL ZH ZL,
// and returns one word per six bytes: the three assembled samples, the latched
// averages and a flag set on the sample that closed an average of
// SAMPLES_PER_AVERAGE samples. Bytes are accepted back to back at one per cycle
// unless a stall backs up to the input. A closing byte is loaded into the input
// register, its word then into the accumulator stage register and then into the
// output register. The path through each stage is one add or one reciprocal
// multiply per axis. Stalls on the output back up through the stages only when a
// closing byte meets a full stage.
module accel_sample_oversampler_core #(
    parameter int SAMPLES_PER_AVERAGE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_sample_x,
    output logic signed [15:0] o_sample_y,
    output logic signed [15:0] o_sample_z,
    output logic signed [15:0] o_average_x,
    output logic signed [15:0] o_average_y,
    output logic signed [15:0] o_average_z,
    output logic        o_average_ready
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_b_valid;
    aso_pkg::t_acc_word  r_b_word;
    logic                r_out_valid;
    aso_pkg::t_sample [aso_pkg::NUM_AXES-1:0] r_samp;
    aso_pkg::t_sample [aso_pkg::NUM_AXES-1:0] r_avg;
    logic                r_flag;

    logic                close;
    aso_pkg::t_acc_word  acc_word;
    aso_pkg::t_sample [aso_pkg::NUM_AXES-1:0] quot;
    logic                adv_a;
    logic                adv_b;
    logic                move_b;

    // Stage handshakes
    assign adv_b      = !r_out_valid || i_out_ready;
    assign move_b     = r_b_valid && adv_b;
    assign adv_a      = r_in_valid && (!close || !r_b_valid || adv_b);
    assign o_in_ready = !r_in_valid || adv_a;

    aso_accum #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (r_in_byte),
        .i_adv   (adv_a),
        .o_close (close),
        .o_word  (acc_word)
    );

    aso_divide #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) u_divide (
        .i_sum  (r_b_word.sum),
        .o_quot (quot)
    );

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_avg       <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv_a) begin
                r_in_valid <= 1'b0;
            end
            if (adv_a && close) begin
                r_b_valid <= 1'b1;
            end else if (move_b) begin
                r_b_valid <= 1'b0;
            end
            if (move_b) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // latched averages only change on a closing sample
            if (move_b && r_b_word.done) begin
                r_avg <= quot;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (adv_a && close) begin
            r_b_word <= acc_word;
        end
        if (move_b) begin
            r_samp <= r_b_word.sample;
            r_flag <= r_b_word.done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_x      = r_samp[0];
    assign o_sample_y      = r_samp[1];
    assign o_sample_z      = r_samp[2];
    assign o_average_x     = r_avg[0];
    assign o_average_y     = r_avg[1];
    assign o_average_z     = r_avg[2];
    assign o_average_ready = r_flag;

endmodule

@@ src/aso_checker.sv @@
// Port-level checks for the oversampling averager, bound to the top level.
`timescale 1ns / 1ps

module aso_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic signed [15:0] o_sample_x,
    input logic signed [15:0] o_sample_y,
    input logic signed [15:0] o_sample_z,
    input logic signed [15:0] o_average_x,
    input logic signed [15:0] o_average_y,
    input logic signed [15:0] o_average_z,
    input logic        o_average_ready
);

    logic signed [15:0] r_last_x;
    logic signed [15:0] r_last_y;
    logic signed [15:0] r_last_z;

    // Averages of the last delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_x <= o_average_x;
            r_last_y <= o_average_y;
            r_last_z <= o_average_z;
        end
    end

    // No word out and input open in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input closed right after reset");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_x)
            && $stable(o_sample_y) && $stable(o_sample_z) && $stable(o_average_x)
            && $stable(o_average_y) && $stable(o_average_z) && $stable(o_average_ready))
        else $error("stalled output word changed");

    // Averages only move on a word that flags a new average
    a_avg_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_average_ready |-> o_average_x == r_last_x
            && o_average_y == r_last_y && o_average_z == r_last_z)
        else $error("averages changed without a new average");

endmodule

bind accel_sample_oversampler_core aso_checker u_aso_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the accelerometer oversampling averager core.
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLES_PER_AVERAGE = 16;
    localparam int RANDOM_SAMPLES      = 150;
    localparam int DRAIN_CYCLES        = 12;
    localparam int HOLD_OFF_CYCLES     = 120;
    localparam int HOLD_OFF_AT_WORD    = 20;

    // One output word as the block returns it
    typedef struct packed {
        aso_pkg::t_sample sx;
        aso_pkg::t_sample sy;
        aso_pkg::t_sample sz;
        aso_pkg::t_sample ax;
        aso_pkg::t_sample ay;
        aso_pkg::t_sample az;
        logic             fresh;
    } t_accel_word;

    // Directed row: one sample plus the word typed in for it
    typedef struct packed {
        aso_pkg::t_sample x;
        aso_pkg::t_sample y;
        aso_pkg::t_sample z;
        t_accel_word      want;
    } t_sample_row;

    // How the random part fills the axes of a sample
    typedef enum int {
        FILL_RANDOM,
        FILL_MAX,
        FILL_MIN,
        FILL_SMALL,
        FILL_EDGES
    } t_fill;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [15:0] o_sample_x;
    logic signed [15:0] o_sample_y;
    logic signed [15:0] o_sample_z;
    logic signed [15:0] o_average_x;
    logic signed [15:0] o_average_y;
    logic signed [15:0] o_average_z;
    logic        o_average_ready;

    accel_sample_oversampler_core #(
        .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_sample_z     (o_sample_z),
        .o_average_x    (o_average_x),
        .o_average_y    (o_average_y),
        .o_average_z    (o_average_z),
        .o_average_ready(o_average_ready)
    );

    // Predictor state, mirrors the block after reset
    logic [2:0]       frame_pos = '0;
    logic [7:0]       held_bytes [0:aso_pkg::HOLD_DEPTH-1] = '{default: 8'h00};
    aso_pkg::t_sum    axis_total [0:aso_pkg::NUM_AXES-1]   = '{default: '0};
    logic [7:0]       window_count = '0;
    aso_pkg::t_sample latched_avg [0:aso_pkg::NUM_AXES-1]  = '{default: '0};

    t_accel_word pending_words [$];
    int          failures = 0;
    int          send_calm_left = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold one accepted byte into the predicted state
    task automatic absorb_byte(input logic [7:0] b, output bit made, output t_accel_word w);
        aso_pkg::t_sample s [0:aso_pkg::NUM_AXES-1];
        logic             rdy;
        made = 1'b0;
        w    = '0;
        rdy  = 1'b0;
        if (frame_pos < aso_pkg::LAST_POS) begin
            held_bytes[frame_pos] = b;
            frame_pos = frame_pos + 3'd1;
        end else begin
            frame_pos = '0;
            s[0] = {held_bytes[0], held_bytes[1]};
            s[1] = {held_bytes[2], held_bytes[3]};
            s[2] = {held_bytes[4], b};
            for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
                axis_total[i] = axis_total[i] + s[i];
            end
            window_count = window_count + 8'd1;
            // Window full: latch truncated averages and restart
            if (window_count >= SAMPLES_PER_AVERAGE) begin
                for (int i = 0; i < aso_pkg::NUM_AXES; i++) begin
                    latched_avg[i] =
                        aso_pkg::t_sample'(int'(axis_total[i]) / int'(window_count));
                    axis_total[i]  = '0;
                end
                window_count = '0;
                rdy = 1'b1;
            end
            w = '{s[0], s[1], s[2], latched_avg[0], latched_avg[1], latched_avg[2], rdy};
            made = 1'b1;
        end
    endtask

    // Offer one byte, wait for the handshake, then log the expected word if any
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_accel_word want);
        int          gap;
        bit          made;
        t_accel_word w;
        gap = (send_calm_left > 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(b, made, w);
        if (made) begin
            pending_words.push_back(typed ? want : w);
        end
        @(negedge i_clk);
    endtask

    // Send one sample as XH XL YH YL ZH ZL
    task automatic send_sample(input aso_pkg::t_sample x, input aso_pkg::t_sample y,
                               input aso_pkg::t_sample z,
                               input bit typed, input t_accel_word want);
        logic [7:0] frame [0:5];
        frame = '{x[15:8], x[7:0], y[15:8], y[7:0], z[15:8], z[7:0]};
        if (send_calm_left > 0) begin
            send_calm_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            send_calm_left = $urandom_range(3, 10);
        end
        for (int k = 0; k < 6; k++) begin
            send_byte(frame[k], typed, want);
        end
    endtask

    function automatic aso_pkg::t_sample pick_value(input t_fill mode);
        case (mode)
            FILL_MAX:   return 16'sh7FFF;
            FILL_MIN:   return 16'sh8000;
            FILL_SMALL: return aso_pkg::t_sample'(int'($urandom_range(0, 16)) - 8);
            FILL_EDGES: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            default:    return aso_pkg::t_sample'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Output monitor: compare each accepted word with the oldest prediction
    always @(posedge i_clk) begin
        t_accel_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected output word: sample_x %0d", o_sample_x);
                failures++;
            end else begin
                w = pending_words.pop_front();
                check_field("sample_x", w.sx, o_sample_x);
                check_field("sample_y", w.sy, o_sample_y);
                check_field("sample_z", w.sz, o_sample_z);
                check_field("average_x", w.ax, o_average_x);
                check_field("average_y", w.ay, o_average_y);
                check_field("average_z", w.az, o_average_z);
                check_field("average_ready", int'(w.fresh), int'(o_average_ready));
            end
        end
    end

    // Receiver: random stalls per word, calm stretches, one long hold-off
    initial begin
        int wait_n;
        int calm_left;
        int words;
        calm_left = 0;
        words     = 0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (calm_left > 0) begin
                wait_n = 0;
                calm_left--;
            end else begin
                wait_n = $urandom_range(0, 5);
                if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(3, 12);
            end
            if (words == HOLD_OFF_AT_WORD) wait_n = HOLD_OFF_CYCLES;
            if (wait_n > 0) begin
                i_out_ready = 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            words++;
            @(negedge i_clk);
        end
    end

    // Stimulus and end of run
    initial begin
        t_sample_row      directed_rows [0:3];
        t_fill            fill_mode;
        int               windows_started;
        aso_pkg::t_sample x, y, z;

        // Samples from reset: averages still zero, no window complete
        directed_rows[0] = '{16'sh7FFF, 16'sh8000, 16'sh0000,
                             '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0, 16'sh0, 16'sh0, 1'b0}};
        directed_rows[1] = '{16'sh8000, 16'sh7FFF, 16'shFFFF,
                             '{16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0, 16'sh0, 16'sh0, 1'b0}};
        directed_rows[2] = '{16'sh0001, 16'shFFFF, 16'sh00FF,
                             '{16'sh0001, 16'shFFFF, 16'sh00FF, 16'sh0, 16'sh0, 16'sh0, 1'b0}};
        directed_rows[3] = '{16'shFF00, 16'sh0080, 16'sh807F,
                             '{16'shFF00, 16'sh0080, 16'sh807F, 16'sh0, 16'sh0, 16'sh0, 1'b0}};

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = 8'h00;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed samples
        foreach (directed_rows[r]) begin
            send_sample(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                        1'b1, directed_rows[r].want);
        end

        // Random samples; each window begun here picks a fill, the first two pinned to the extremes
        fill_mode       = FILL_RANDOM;
        windows_started = 0;
        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            if (window_count == 0) begin
                case (windows_started)
                    0:       fill_mode = FILL_MAX;
                    1:       fill_mode = FILL_MIN;
                    default: begin
                        case ($urandom_range(0, 5)) inside
                            [0:2]:   fill_mode = FILL_RANDOM;
                            3:       fill_mode = FILL_SMALL;
                            default: fill_mode = FILL_EDGES;
                        endcase
                    end
                endcase
                windows_started++;
            end
            x = pick_value(fill_mode);
            y = pick_value(fill_mode);
            z = pick_value(fill_mode);
            send_sample(x, y, z, 1'b0, '0);
        end
        i_in_valid = 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ accel_sample_oversampler_core.f @@
src/aso_pkg.sv
src/aso_accum.sv
src/aso_divide.sv
src/accel_sample_oversampler_core.sv
src/aso_checker.sv
sim/testbench.sv
